[rtl/core/cnv_pkg.sv]
// Shared constants, types and state encodings for the 5x5 convolution block.
`default_nettype none
package cnv_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int KERNEL_SIZE = 5;
  localparam int KAREA       = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES       = KERNEL_SIZE - 1;

  localparam int DATA_W      = 16;
  localparam int WIDTH_W     = 6;
  localparam int IDX_W       = 5;
  localparam int OUT_COORD_W = 5;
  localparam int COORD_W     = $clog2(MAX_WIDTH);
  localparam int TAP_W       = $clog2(KAREA);
  localparam int LINE_W      = LINES * DATA_W;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = PROD_W + $clog2(KAREA);
  localparam int SCALED_W    = ACC_W + DATA_W;
  localparam int FRAC_SHIFT  = 26;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_OUT_COORD = MAX_WIDTH - KERNEL_SIZE;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 1'b1;

  localparam logic [WIDTH_W-1:0]       WIDTH_RESET = 6'd32;
  localparam logic signed [DATA_W-1:0] SCALE_RESET = 16'sd4096;

  typedef logic signed [DATA_W-1:0] pix_t;
  typedef pix_t [KAREA-1:0] window_t;
  typedef pix_t [KERNEL_SIZE-1:0] column_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CALC
  } top_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_MUL,
    MS_TAIL,
    MS_SCALE,
    MS_ROUND
  } mac_state_t;

  typedef struct packed {
    logic                   emit;
    logic [OUT_COORD_W-1:0] row;
    logic [OUT_COORD_W-1:0] col;
    logic                   last;
  } win_info_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    pix_t             value;
  } weight_wr_t;

endpackage
`default_nettype wire

[rtl/core/cnv_ifs.sv]
// Handshake channel interfaces: pixel/weight feed, result and configuration write.
`default_nettype none
interface cnv_feed_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [cnv_pkg::IDX_W-1:0] weight_index;
  cnv_pkg::pix_t             weight_value;
  cnv_pkg::pix_t             pixel_value;
  modport source (output valid, opcode, weight_index, weight_value, pixel_value, input ready);
  modport sink (input valid, opcode, weight_index, weight_value, pixel_value, output ready);
endinterface

interface cnv_result_if;
  logic                            valid;
  logic                            ready;
  cnv_pkg::pix_t                   conv_value;
  logic [cnv_pkg::OUT_COORD_W-1:0] out_row;
  logic [cnv_pkg::OUT_COORD_W-1:0] out_col;
  logic                            last_of_map;
  modport source (output valid, conv_value, out_row, out_col, last_of_map, input ready);
  modport sink (input valid, conv_value, out_row, out_col, last_of_map, output ready);
endinterface

interface cnv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cnv_pkg::CFG_IDX_W-1:0] index;
  logic [cnv_pkg::DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/cnv_window.sv]
// Line store memory, raster counters and 5x5 pixel window.
`default_nettype none
module cnv_window (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic                      upd_en,
  input  wire logic                      restart,
  input  wire cnv_pkg::pix_t             pixel_in,
  input  wire logic [cnv_pkg::COORD_W:0] eff_w,
  output cnv_pkg::window_t               window,
  output cnv_pkg::win_info_t             info
);

  logic [cnv_pkg::LINE_W-1:0]  line_mem [cnv_pkg::MAX_WIDTH];
  logic [cnv_pkg::LINE_W-1:0]  line_rd;
  logic [cnv_pkg::LINE_W-1:0]  line_wr;
  cnv_pkg::pix_t               pix_hold;
  cnv_pkg::column_t            column;
  logic [cnv_pkg::COORD_W-1:0] row;
  logic [cnv_pkg::COORD_W-1:0] col;
  logic [cnv_pkg::COORD_W-1:0] row_e;
  logic [cnv_pkg::COORD_W-1:0] col_e;
  logic [cnv_pkg::COORD_W:0]   row_inc;
  logic [cnv_pkg::COORD_W:0]   col_inc;
  logic [cnv_pkg::COORD_W:0]   w_last;

  always_comb begin
    row_e   = ({1'b0, row} >= eff_w) ? '0 : row;
    col_e   = ({1'b0, col} >= eff_w) ? '0 : col;
    row_inc = {1'b0, row_e} + 1'b1;
    col_inc = {1'b0, col_e} + 1'b1;
    w_last  = eff_w - 1'b1;
    for (int k = 0; k < cnv_pkg::LINES; k++) begin
      column[k] = line_rd[k*cnv_pkg::DATA_W +: cnv_pkg::DATA_W];
    end
    column[cnv_pkg::LINES] = pix_hold;
    for (int k = 0; k < cnv_pkg::LINES; k++) begin
      line_wr[k*cnv_pkg::DATA_W +: cnv_pkg::DATA_W] = column[k+1];
    end
    info.emit = (row_e >= cnv_pkg::COORD_W'(cnv_pkg::LINES)) &&
                (col_e >= cnv_pkg::COORD_W'(cnv_pkg::LINES));
    info.row  = cnv_pkg::OUT_COORD_W'(row_e - cnv_pkg::COORD_W'(cnv_pkg::LINES));
    info.col  = cnv_pkg::OUT_COORD_W'(col_e - cnv_pkg::COORD_W'(cnv_pkg::LINES));
    info.last = ({1'b0, row_e} == w_last) && ({1'b0, col_e} == w_last);
  end

  // read one column of older rows, write it back shifted up by one row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      line_rd  <= line_mem[col_e];
      pix_hold <= pixel_in;
    end
    if (upd_en) begin
      line_mem[col_e] <= line_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (restart) begin
      row <= '0;
      col <= '0;
    end else if (upd_en) begin
      if (col_inc >= eff_w) begin
        col <= '0;
        row <= (row_inc >= eff_w) ? '0 : row_inc[cnv_pkg::COORD_W-1:0];
      end else begin
        col <= col_inc[cnv_pkg::COORD_W-1:0];
      end
    end
  end

  // shift window left, insert the new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (upd_en) begin
      for (int r = 0; r < cnv_pkg::KERNEL_SIZE; r++) begin
        for (int c = 0; c < cnv_pkg::KERNEL_SIZE - 1; c++) begin
          window[r*cnv_pkg::KERNEL_SIZE + c] <= window[r*cnv_pkg::KERNEL_SIZE + c + 1];
        end
        window[r*cnv_pkg::KERNEL_SIZE + cnv_pkg::KERNEL_SIZE - 1] <= column[r];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/cnv_mac.sv]
// Kernel weights, shared multiply-accumulate, scaling, rounding, saturation and result register.
`default_nettype none
module cnv_mac (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cnv_pkg::weight_wr_t  wwr,
  input  wire logic                 start,
  input  wire cnv_pkg::win_info_t   info,
  input  wire cnv_pkg::window_t     window,
  input  wire cnv_pkg::pix_t        scale,
  output logic                      done,
  cnv_result_if.source              result
);

  cnv_pkg::mac_state_t                state;
  cnv_pkg::mac_state_t                state_next;
  cnv_pkg::pix_t [cnv_pkg::KAREA-1:0] kernel;
  logic [cnv_pkg::TAP_W-1:0]          k;
  logic signed [cnv_pkg::PROD_W-1:0]  prod;
  logic                               prod_vld;
  logic signed [cnv_pkg::ACC_W-1:0]   acc;
  logic signed [cnv_pkg::SCALED_W-1:0] scaled;
  logic signed [cnv_pkg::SCALED_W-1:0] rnd;
  logic signed [cnv_pkg::SCALED_W-1:0] shifted;
  logic [cnv_pkg::SCALED_W-cnv_pkg::DATA_W:0] hi_bits;
  cnv_pkg::pix_t                      sat;
  cnv_pkg::win_info_t                 tag;
  logic                               out_free;
  logic                               mul_en;
  logic                               scale_en;
  logic                               load_out;

  assign out_free = !result.valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      cnv_pkg::MS_IDLE:  if (start) state_next = cnv_pkg::MS_MUL;
      cnv_pkg::MS_MUL:   if (k == cnv_pkg::TAP_W'(cnv_pkg::KAREA - 1)) begin
        state_next = cnv_pkg::MS_TAIL;
      end
      cnv_pkg::MS_TAIL:  state_next = cnv_pkg::MS_SCALE;
      cnv_pkg::MS_SCALE: state_next = cnv_pkg::MS_ROUND;
      cnv_pkg::MS_ROUND: if (out_free) state_next = cnv_pkg::MS_IDLE;
      default:           state_next = cnv_pkg::MS_IDLE;
    endcase
  end

  always_comb begin
    mul_en   = (state == cnv_pkg::MS_MUL);
    scale_en = (state == cnv_pkg::MS_SCALE);
    load_out = (state == cnv_pkg::MS_ROUND) && out_free;
    done     = load_out;
  end

  // round to nearest with ties upward, then saturate to Q8.8
  always_comb begin
    rnd     = scaled + (cnv_pkg::SCALED_W'(1) <<< (cnv_pkg::FRAC_SHIFT - 1));
    shifted = rnd >>> cnv_pkg::FRAC_SHIFT;
    hi_bits = shifted[cnv_pkg::SCALED_W-1:cnv_pkg::DATA_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      sat = shifted[cnv_pkg::DATA_W-1:0];
    end else if (shifted[cnv_pkg::SCALED_W-1]) begin
      sat = {1'b1, {(cnv_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(cnv_pkg::DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnv_pkg::MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel <= '0;
    end else if (wwr.en && (wwr.idx < cnv_pkg::IDX_W'(cnv_pkg::KAREA))) begin
      kernel[wwr.idx] <= wwr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= mul_en;
      if (start) begin
        k <= '0;
      end else if (mul_en) begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      tag <= info;
    end else if (prod_vld) begin
      acc <= acc + cnv_pkg::ACC_W'(prod);
    end
    if (mul_en) begin
      prod <= kernel[k] * window[k];
    end
    if (scale_en) begin
      scaled <= cnv_pkg::SCALED_W'(acc) * cnv_pkg::SCALED_W'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.conv_value  <= sat;
      result.out_row     <= tag.row;
      result.out_col     <= tag.col;
      result.last_of_map <= tag.last;
    end
  end

endmodule
`default_nettype wire

[rtl/core/conv2d_5x5_scaled.sv]
// Top level of the scaled 5x5 valid convolution over a raster pixel stream.
// A pixel that completes a window goes through a line store read and window update, then
// one multiplier shared over 25 taps, scaling and rounding; no new pixel is taken until
// the result is loaded, which waits while the previous result is still unaccepted. A pixel
// that gives no result takes a line store read, then a write back. Reset clears counters,
// window, weights, state, configuration and result valid; the line store needs no clearing.
`default_nettype none
module conv2d_5x5_scaled (
  input wire logic  clk,
  input wire logic  rst,
  cnv_feed_if.sink     feed,
  cnv_result_if.source result,
  cnv_cfg_if.sink      cfg
);

  cnv_pkg::top_state_t          state;
  cnv_pkg::top_state_t          state_next;
  logic [cnv_pkg::WIDTH_W-1:0]  frame_width;
  cnv_pkg::pix_t                output_scale;
  logic [cnv_pkg::COORD_W:0]    eff_w;
  logic                         feed_acc;
  logic                         cfg_acc;
  logic                         rd_en;
  logic                         upd_en;
  logic                         start;
  logic                         restart;
  logic                         done;
  cnv_pkg::weight_wr_t          wwr;
  cnv_pkg::window_t             window;
  cnv_pkg::win_info_t           info;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign feed_acc  = feed.valid && feed.ready;
  assign restart   = cfg_acc && (cfg.index == cnv_pkg::CFG_FRAME_WIDTH);

  always_comb begin
    if (frame_width < cnv_pkg::WIDTH_W'(cnv_pkg::KERNEL_SIZE)) begin
      eff_w = (cnv_pkg::COORD_W+1)'(cnv_pkg::KERNEL_SIZE);
    end else if (32'(frame_width) > cnv_pkg::MAX_WIDTH) begin
      eff_w = (cnv_pkg::COORD_W+1)'(cnv_pkg::MAX_WIDTH);
    end else begin
      eff_w = (cnv_pkg::COORD_W+1)'(frame_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cnv_pkg::WIDTH_RESET;
      output_scale <= cnv_pkg::SCALE_RESET;
    end else if (cfg_acc) begin
      unique case (cfg.index)
        cnv_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg.data[cnv_pkg::WIDTH_W-1:0];
        cnv_pkg::CFG_OUTPUT_SCALE: output_scale <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cnv_pkg::ST_IDLE:  if (feed_acc && (feed.opcode == cnv_pkg::OP_PIXEL)) begin
        state_next = cnv_pkg::ST_FETCH;
      end
      cnv_pkg::ST_FETCH: state_next = info.emit ? cnv_pkg::ST_CALC : cnv_pkg::ST_IDLE;
      cnv_pkg::ST_CALC:  if (done) state_next = cnv_pkg::ST_IDLE;
      default:           state_next = cnv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    feed.ready = (state == cnv_pkg::ST_IDLE);
    rd_en      = feed_acc && (feed.opcode == cnv_pkg::OP_PIXEL);
    upd_en     = (state == cnv_pkg::ST_FETCH);
    start      = upd_en && info.emit;
    wwr.en     = feed_acc && (feed.opcode == cnv_pkg::OP_WEIGHT);
    wwr.idx    = feed.weight_index;
    wwr.value  = feed.weight_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  cnv_window u_window (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .upd_en   (upd_en),
    .restart  (restart),
    .pixel_in (feed.pixel_value),
    .eff_w    (eff_w),
    .window   (window),
    .info     (info)
  );

  cnv_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .wwr    (wwr),
    .start  (start),
    .info   (info),
    .window (window),
    .scale  (output_scale),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

[rtl/core/cnv_checker.sv]
// Port-level assertions for the convolution block and their bind to the top level.
`default_nettype none
module cnv_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            feed_valid,
  input wire logic                            feed_ready,
  input wire logic                            feed_opcode,
  input wire logic                            res_valid,
  input wire logic                            res_ready,
  input wire logic [cnv_pkg::DATA_W-1:0]      res_value,
  input wire logic [cnv_pkg::OUT_COORD_W-1:0] res_row,
  input wire logic [cnv_pkg::OUT_COORD_W-1:0] res_col,
  input wire logic                            res_last
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_row) &&
      $stable(res_col) && $stable(res_last))
    else $error("result changed while stalled");

  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    feed_valid && feed_ready && (feed_opcode == cnv_pkg::OP_PIXEL) |=> !feed_ready)
    else $error("pixel request accepted on consecutive cycles");

  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_row == res_col)
    else $error("last of map off the diagonal");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res_row) <= cnv_pkg::MAX_OUT_COORD) &&
      (32'(res_col) <= cnv_pkg::MAX_OUT_COORD))
    else $error("output coordinate out of range");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind conv2d_5x5_scaled cnv_checker u_cnv_checker (
  .clk         (clk),
  .rst         (rst),
  .feed_valid  (feed.valid),
  .feed_ready  (feed.ready),
  .feed_opcode (feed.opcode),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_value   (result.conv_value),
  .res_row     (result.out_row),
  .res_col     (result.out_col),
  .res_last    (result.last_of_map)
);
`default_nettype wire

[tb/conv_window_check.sv]
// Predictor and result comparator for the scaled 5x5 convolution testbench.
`timescale 1ns / 100ps
module conv_window_check
  import cnv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  cnv_feed_if    feed,
  cnv_result_if  result,
  cnv_cfg_if     cfg,
  output int     errors,
  output int     outstanding
);

  typedef struct packed {
    pix_t                   conv_value;
    logic [OUT_COORD_W-1:0] out_row;
    logic [OUT_COORD_W-1:0] out_col;
    logic                   last_of_map;
  } conv_out_t;

  logic [WIDTH_W-1:0] width_reg;
  pix_t               scale_reg;
  pix_t               weights [KAREA];
  pix_t               lines [LINES][MAX_WIDTH];
  pix_t               win [KERNEL_SIZE][KERNEL_SIZE];
  int unsigned        row_pos;
  int unsigned        col_pos;
  conv_out_t          conv_q [$];

  function automatic bit conv_pixel(input pix_t px, output conv_out_t res);
    int unsigned w;
    pix_t        fresh_col [KERNEL_SIZE];
    longint      acc;
    longint      scaled;
    w = int'(width_reg);
    if (w < KERNEL_SIZE) w = KERNEL_SIZE;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= w) row_pos = 0;
    for (int k = 0; k < LINES; k++) fresh_col[k] = lines[k][col_pos];
    fresh_col[LINES] = px;
    for (int k = 0; k < LINES; k++) lines[k][col_pos] = fresh_col[k+1];
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) win[r][c] = win[r][c+1];
      win[r][KERNEL_SIZE-1] = fresh_col[r];
    end
    res = '0;
    conv_pixel = (row_pos >= LINES) && (col_pos >= LINES);
    if (conv_pixel) begin
      acc = 0;
      for (int r = 0; r < KERNEL_SIZE; r++)
        for (int c = 0; c < KERNEL_SIZE; c++)
          acc += longint'(weights[r*KERNEL_SIZE+c]) * longint'(win[r][c]);
      scaled = (acc * longint'(scale_reg) + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (scaled > 32767) scaled = 32767;
      else if (scaled < -32768) scaled = -32768;
      res.conv_value  = scaled[DATA_W-1:0];
      res.out_row     = OUT_COORD_W'(row_pos - LINES);
      res.out_col     = OUT_COORD_W'(col_pos - LINES);
      res.last_of_map = (row_pos == w - 1) && (col_pos == w - 1);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= w) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  always @(posedge clk) begin
    conv_out_t made;
    conv_out_t want;
    if (rst) begin
      width_reg = WIDTH_RESET;
      scale_reg = SCALE_RESET;
      for (int k = 0; k < KAREA; k++) weights[k] = '0;
      for (int k = 0; k < LINES; k++)
        for (int c = 0; c < MAX_WIDTH; c++) lines[k][c] = '0;
      for (int r = 0; r < KERNEL_SIZE; r++)
        for (int c = 0; c < KERNEL_SIZE; c++) win[r][c] = '0;
      row_pos = 0;
      col_pos = 0;
      conv_q.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FRAME_WIDTH: begin
            width_reg = cfg.data[WIDTH_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          CFG_OUTPUT_SCALE: begin
            scale_reg = cfg.data;
          end
          default: ;
        endcase
      end
      if (feed.valid && feed.ready) begin
        if (feed.opcode == OP_PIXEL) begin
          if (conv_pixel(feed.pixel_value, made)) conv_q.push_back(made);
        end else if (feed.weight_index < KAREA) begin
          weights[feed.weight_index] = feed.weight_value;
        end
      end
      if (result.valid && result.ready) begin
        if (conv_q.size() == 0) begin
          errors = errors + 1;
          $error("unexpected result: conv_value %0d row %0d col %0d", result.conv_value,
                 result.out_row, result.out_col);
        end else begin
          want = conv_q.pop_front();
          if (result.conv_value !== want.conv_value) begin
            errors = errors + 1;
            $error("conv_value: expected %0d, got %0d", want.conv_value, result.conv_value);
          end
          if (result.out_row !== want.out_row) begin
            errors = errors + 1;
            $error("out_row: expected %0d, got %0d", want.out_row, result.out_row);
          end
          if (result.out_col !== want.out_col) begin
            errors = errors + 1;
            $error("out_col: expected %0d, got %0d", want.out_col, result.out_col);
          end
          if (result.last_of_map !== want.last_of_map) begin
            errors = errors + 1;
            $error("last_of_map: expected %0d, got %0d", want.last_of_map, result.last_of_map);
          end
        end
      end
      outstanding <= conv_q.size();
    end
  end

endmodule

[tb/tb_conv2d_5x5_scaled.sv]
// Top of the 5x5 convolution testbench: clock, reset, pixel, weight and config stimulus, receiver, verdict.
`timescale 1ns / 100ps
module tb_conv2d_5x5_scaled;
  import cnv_pkg::*;

  localparam int ITEM_TARGET   = 1850;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int   quiet;
  int   burst_left;
  bit   steady;
  bit   long_hold;

  cnv_feed_if   feed ();
  cnv_result_if result ();
  cnv_cfg_if    cfg ();

  conv2d_5x5_scaled dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .result (result),
    .cfg    (cfg)
  );

  conv_window_check window_check (
    .clk         (clk),
    .rst         (rst),
    .feed        (feed),
    .result      (result),
    .cfg         (cfg),
    .errors      (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pix_t sample_word();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic offer(input logic op, input logic [IDX_W-1:0] idx, input pix_t wv,
                       input pix_t pv);
    feed.valid        <= 1'b1;
    feed.opcode       <= op;
    feed.weight_index <= idx;
    feed.weight_value <= wv;
    feed.pixel_value  <= pv;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
    if (!steady) begin
      if (burst_left == 0) begin
        feed.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic offer_pixel(input pix_t pv);
    offer(OP_PIXEL, IDX_W'($urandom), pix_t'($urandom), pv);
  endtask

  task automatic offer_weight(input logic [IDX_W-1:0] idx, input pix_t wv);
    offer(OP_WEIGHT, idx, wv, pix_t'($urandom));
  endtask

  task automatic settle();
    feed.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random ready pattern, with one long hold-off on request
  initial begin
    int seg;
    int style;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg   = $urandom_range(1, 60);
      style = $urandom_range(0, 3);
      repeat (seg) begin
        case (style)
          0, 1:    result.ready <= 1'b1;
          2:       result.ready <= 1'($urandom_range(0, 1));
          default: result.ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (feed.valid && feed.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int               items;
    int               ph;
    int               wsel;
    int               ew;
    int               npix;
    int               n_img;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] scale;

    feed.valid        <= 1'b0;
    feed.opcode       <= OP_WEIGHT;
    feed.weight_index <= '0;
    feed.weight_value <= '0;
    feed.pixel_value  <= '0;
    cfg.valid         <= 1'b0;
    cfg.index         <= CFG_FRAME_WIDTH;
    cfg.data          <= '0;
    burst_left = 0;
    steady     = 1'b0;
    long_hold  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest image, extreme weights and pixels, ignored weight indexes
    write_reg(CFG_FRAME_WIDTH, DATA_W'(KERNEL_SIZE));
    write_reg(CFG_OUTPUT_SCALE, 16'h7fff);
    offer_weight(IDX_W'(0), 16'sh7fff);
    offer_weight(IDX_W'(KAREA - 1), 16'sh8000);
    offer_weight(IDX_W'(KAREA / 2), 16'sh4000);
    offer_weight(IDX_W'(KAREA), 16'sh1234);
    offer_weight('1, -16'sd1);
    for (int i = 0; i < KAREA; i++)
      offer_pixel(i == 0 ? 16'sh7fff : (i == KAREA - 1 ? 16'sh8000 : sample_word()));

    items = 0;
    ph    = 0;
    while (items < ITEM_TARGET) begin
      settle();
      if (ph == 0) wsel = 63;
      else begin
        case ($urandom_range(0, 9))
          0:       wsel = $urandom_range(0, KERNEL_SIZE - 1);
          1, 2:    wsel = $urandom_range(10, 16);
          default: wsel = $urandom_range(KERNEL_SIZE, 9);
        endcase
      end
      word = DATA_W'($urandom);
      word[WIDTH_W-1:0] = WIDTH_W'(wsel);
      write_reg(CFG_FRAME_WIDTH, word);
      if (ph <= 3 || $urandom_range(0, 2) == 0) begin
        case (ph)
          0:       scale = 16'h1000;
          1:       scale = 16'h8000;
          2:       scale = 16'h7fff;
          3:       scale = 16'h0000;
          default: scale = $urandom_range(0, 1) ? sample_word() : DATA_W'($urandom_range(0, 8192));
        endcase
        write_reg(CFG_OUTPUT_SCALE, scale);
      end
      if (ph == 0 || $urandom_range(0, 1) == 1) begin
        for (int k = 0; k < KAREA; k++) begin
          offer_weight(IDX_W'(k), sample_word());
          items++;
        end
      end
      ew = wsel < KERNEL_SIZE ? KERNEL_SIZE : (wsel > MAX_WIDTH ? MAX_WIDTH : wsel);
      steady = ($urandom_range(0, 3) == 0);
      if (ph == 0) long_hold = 1'b1;
      n_img = (ph == 0) ? 1 : $urandom_range(1, 3);
      for (int m = 0; m < n_img && items < ITEM_TARGET; m++) begin
        npix = ew * ew;
        if ($urandom_range(0, 9) == 0) npix = $urandom_range(1, npix - 1);
        for (int p = 0; p < npix && items < ITEM_TARGET; p++) begin
          if ($urandom_range(0, 39) == 0) begin
            word[IDX_W-1:0] = IDX_W'($urandom_range(0, 31));
            offer_weight(word[IDX_W-1:0], sample_word());
            items++;
          end
          offer_pixel(sample_word());
          items++;
        end
      end
      ph++;
    end
    settle();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
